### hw/rtl/grid_ray_caster_column_assert.svh
// Assertion macros for the grid ray caster column block.
// Included by the top level; no other dependencies.
`ifndef GRID_RAY_CASTER_COLUMN_ASSERT_SVH
`define GRID_RAY_CASTER_COLUMN_ASSERT_SVH

// same-cycle implication
`define GRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grc: same-cycle check failed");

// next-cycle implication
`define GRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grc: next-cycle check failed");

`endif

### hw/rtl/grc_pkg.sv
// Shared types, widths and constants of the grid ray caster column block.
// No dependencies.
package grc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;
    localparam int MAP_WIDTH_DEF     = 64;
    localparam int MAP_HEIGHT_DEF    = 64;

    localparam int QUEUE_DEPTH = 2;

    localparam int N_W     = 25;
    localparam int RAY_W   = 28;
    localparam int SQ_W    = 2 * RAY_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int NUM_W   = 48;
    localparam int DEN_W   = 28;
    localparam int ACC_W   = 48;
    localparam int CRD_W   = 10;
    localparam int H_W     = 21;

    localparam logic [31:0] DELTA_MAX  = 32'hFFFF_FFFF;
    localparam logic [7:0]  SHADE_FULL = 8'd255;
    localparam logic [7:0]  SHADE_HALF = 8'd127;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    typedef enum logic [2:0] {
        CFG_PLAYER_X = 3'd0,
        CFG_PLAYER_Y = 3'd1,
        CFG_DIR_X    = 3'd2,
        CFG_DIR_Y    = 3'd3,
        CFG_PLANE_X  = 3'd4,
        CFG_PLANE_Y  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic       req_type;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       is_wall;
        logic [8:0] screen_column;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  slice_top;
        logic [7:0]  slice_bottom;
        logic [7:0]  shade;
        logic        hit_side;
        logic [5:0]  hit_cell_x;
        logic [5:0]  hit_cell_y;
        logic [15:0] wall_distance;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        player_x;
        logic [15:0]        player_y;
        logic signed [15:0] view_dir_x;
        logic signed [15:0] view_dir_y;
        logic signed [15:0] camera_plane_x;
        logic signed [15:0] camera_plane_y;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        player_x:       16'd0,
        player_y:       16'd0,
        view_dir_x:     16'sd16384,
        view_dir_y:     16'sd0,
        camera_plane_x: 16'sd0,
        camera_plane_y: 16'sd10813
    };

    typedef struct packed {
        logic clearing;
        logic res_valid;
    } t_back_status;

endpackage

### hw/rtl/grid_ray_caster_column.sv
// Top level of the grid ray caster column block.
// Depends on grc_pkg, grc_front, grc_back and grid_ray_caster_column_assert.svh.
//
// Usage:
//   Request channel (i_push/o_full, i_in_item): a write beat stores one map
//   cell (writes outside the map are dropped); a cast beat traces the ray of
//   one screen column and yields exactly one result.
//   Result channel (o_empty/i_pop, o_out_item): the oldest result is shown
//   while o_empty is low and leaves on a beat with i_pop high.
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data): always
//   ready; write registers only while the block is idle.
//   A cast runs the ray setup, the square root, the two step lengths, the
//   grid walk with a map RAM read per cell walked, and the slice height in
//   turn; the divider is shared by the step lengths and the slice height.
//   One cast is in the back end at a time; a map write is done there
//   without leaving the idle state.
//   After reset the map RAM is cleared one cell per cycle (all 2^(log2 MAP_WIDTH
//   + log2 MAP_HEIGHT) cells, 4096 by default) with o_full high.
//   When the receiver stalls the finished result is held, the back end waits
//   with the next result, and the two-entry front queue still takes requests.
`include "grid_ray_caster_column_assert.svh"

module grid_ray_caster_column #(
    parameter int SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAP_WIDTH     = grc_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT    = grc_pkg::MAP_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  grc_pkg::t_in_item  i_in_item,
    output logic               o_empty,
    input  logic               i_pop,
    output grc_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    grc_pkg::t_cfg         r_cfg;
    grc_pkg::t_back_status w_status;
    grc_pkg::t_in_item     w_cmd;
    logic                  w_cmd_valid;
    logic                  w_cmd_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= grc_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (grc_pkg::t_cfg_idx'(i_cfg_index))
                grc_pkg::CFG_PLAYER_X: r_cfg.player_x       <= i_cfg_data;
                grc_pkg::CFG_PLAYER_Y: r_cfg.player_y       <= i_cfg_data;
                grc_pkg::CFG_DIR_X:    r_cfg.view_dir_x     <= $signed(i_cfg_data);
                grc_pkg::CFG_DIR_Y:    r_cfg.view_dir_y     <= $signed(i_cfg_data);
                grc_pkg::CFG_PLANE_X:  r_cfg.camera_plane_x <= $signed(i_cfg_data);
                grc_pkg::CFG_PLANE_Y:  r_cfg.camera_plane_y <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    grc_front #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_in_item   (i_in_item),
        .i_block     (w_status.clearing),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    grc_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_WIDTH     (MAP_WIDTH),
        .MAP_HEIGHT    (MAP_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_pop       (i_pop),
        .o_res       (o_out_item),
        .o_status    (w_status)
    );

    assign o_empty = !w_status.res_valid;

    `GRC_ASSERT_IMPLY(a_clear_blocks_input, i_clk, i_rst_n, w_status.clearing, o_full)
    `GRC_ASSERT_IMPLY(a_no_result_in_clear, i_clk, i_rst_n, !o_empty, !w_status.clearing)
    `GRC_ASSERT_NEXT(a_no_clear_after_accept, i_clk, i_rst_n, i_push && !o_full, !w_status.clearing)

endmodule

### hw/rtl/grc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/grc_front.sv
// Front end: accepts request beats, drops writes outside the map, queues the rest.
// Depends on grc_pkg.
module grc_front #(
    parameter int MAP_WIDTH  = grc_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT = grc_pkg::MAP_HEIGHT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  grc_pkg::t_in_item i_in_item,
    input  logic              i_block,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output grc_pkg::t_in_item o_cmd
);

    localparam int DEPTH = grc_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [8:0] MW = 9'(MAP_WIDTH);
    localparam logic [8:0] MH = 9'(MAP_HEIGHT);

    grc_pkg::t_in_item r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          keep;
    logic          enq;
    logic          deq;

    assign o_full      = (r_cnt == CW'(DEPTH)) || i_block;
    assign keep        = (i_in_item.req_type == grc_pkg::REQ_CAST)
                       || (({3'b0, i_in_item.cell_x} < MW) && ({3'b0, i_in_item.cell_y} < MH));
    assign enq         = i_push && !o_full && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign deq         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + PW'(1);
            end
            if (deq) begin
                r_rp <= r_rp + PW'(1);
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wp] <= i_in_item;
        end
    end

endmodule

### hw/rtl/grc_divider.sv
// Restoring divider, one quotient bit per cycle.
// No dependencies beyond grc_pkg defaults.
module grc_divider #(
    parameter int NUM_W = grc_pkg::NUM_W,
    parameter int DEN_W = grc_pkg::DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/grc_sqrt.sv
// Integer square root, one result bit per cycle (digit-by-digit).
// No dependencies beyond grc_pkg defaults.
module grc_sqrt #(
    parameter int SQ_W = grc_pkg::SQ_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SQ_W-1:0]    i_val,
    output logic               o_done,
    output logic [SQ_W/2-1:0]  o_root
);

    localparam int ROOT_W = SQ_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_v;
    logic [SQ_W-1:0]  r_r;
    logic [SQ_W-1:0]  r_b;
    logic [SQ_W-1:0]  trial;

    assign trial = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ROOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
            r_b <= {2'b01, {(SQ_W-2){1'b0}}};
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule

### hw/rtl/grc_back.sv
// Back end: map clearing, map writes, ray setup, DDA walk and slice math.
// Depends on grc_pkg, grc_ram, grc_divider, grc_sqrt.
module grc_back #(
    parameter int SCREEN_WIDTH  = grc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grc_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAP_WIDTH     = grc_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT    = grc_pkg::MAP_HEIGHT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  grc_pkg::t_cfg         i_cfg,
    input  logic                  i_cmd_valid,
    output logic                  o_cmd_ready,
    input  grc_pkg::t_in_item     i_cmd,
    input  logic                  i_pop,
    output grc_pkg::t_out_item    o_res,
    output grc_pkg::t_back_status o_status
);

    localparam int XW     = $clog2(MAP_WIDTH);
    localparam int YW     = $clog2(MAP_HEIGHT);
    localparam int AW     = XW + YW;
    localparam int DEPTH  = 2 ** AW;
    localparam int N_W    = grc_pkg::N_W;
    localparam int RAY_W  = grc_pkg::RAY_W;
    localparam int SQ_W   = grc_pkg::SQ_W;
    localparam int ROOT_W = grc_pkg::ROOT_W;
    localparam int NUM_W  = grc_pkg::NUM_W;
    localparam int DEN_W  = grc_pkg::DEN_W;
    localparam int ACC_W  = grc_pkg::ACC_W;
    localparam int CRD_W  = grc_pkg::CRD_W;
    localparam int H_W    = grc_pkg::H_W;

    // column scale col * 2^15 / SCREEN_WIDTH by reciprocal multiplication
    localparam int N_FRAC = 36;
    localparam logic [35:0] N_RECIP =
        36'(((64'd1 << N_FRAC) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    localparam logic signed [N_W-1:0]   N_BIAS = N_W'(16384);
    localparam logic signed [CRD_W-1:0] MX_LIM = CRD_W'(MAP_WIDTH);
    localparam logic signed [CRD_W-1:0] MY_LIM = CRD_W'(MAP_HEIGHT);
    localparam logic signed [H_W:0]     HALF_S = (H_W + 1)'(SCREEN_HEIGHT / 2);
    localparam logic [H_W-1:0]          HALF_U = H_W'(SCREEN_HEIGHT / 2);
    localparam logic [H_W-1:0]          SH_U   = H_W'(SCREEN_HEIGHT);
    localparam logic [7:0]              BOT_MAX = 8'(SCREEN_HEIGHT - 1);

    typedef enum logic [17:0] {
        S_CLEAR = 18'h00001,
        S_IDLE  = 18'h00002,
        S_RAY   = 18'h00008,
        S_RAY2  = 18'h00010,
        S_SQ    = 18'h00020,
        S_SQST  = 18'h00040,
        S_SQRT  = 18'h00080,
        S_DXST  = 18'h00100,
        S_DX    = 18'h00200,
        S_DYST  = 18'h00400,
        S_DY    = 18'h00800,
        S_INIT  = 18'h01000,
        S_WALK  = 18'h02000,
        S_WCHK  = 18'h04000,
        S_HST   = 18'h08000,
        S_HDIV  = 18'h10000,
        S_DONE  = 18'h20000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [AW-1:0] r_clr;
    logic          r_res_valid;
    grc_pkg::t_out_item r_res;

    logic signed [N_W-1:0]       r_n;
    logic signed [N_W+15:0]      r_px;
    logic signed [N_W+15:0]      r_py;
    logic signed [RAY_W-1:0]     r_rx;
    logic signed [RAY_W-1:0]     r_ry;
    logic signed [2*RAY_W-1:0]   r_sqx;
    logic signed [2*RAY_W-1:0]   r_sqy;
    logic [ROOT_W-1:0]           r_len;
    logic [31:0]                 r_dx;
    logic [31:0]                 r_dy;
    logic [ACC_W-1:0]            r_sidex;
    logic [ACC_W-1:0]            r_sidey;
    logic signed [CRD_W-1:0]     r_mx;
    logic signed [CRD_W-1:0]     r_my;
    logic                        r_negx;
    logic                        r_negy;
    logic                        r_side;
    logic [15:0]                 r_wd;
    logic [7:0]                  r_top;
    logic [7:0]                  r_bot;

    logic              take;
    logic              res_load;
    logic [44:0]       n_prod;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [31:0]       div_sat;
    logic              sq_start;
    logic [SQ_W-1:0]   sq_val;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic [DEN_W-1:0]  mag_x;
    logic [DEN_W-1:0]  mag_y;
    logic [10:0]       fmx;
    logic [10:0]       fmy;
    logic [42:0]       mul_x;
    logic [42:0]       mul_y;
    logic              step_x;
    logic signed [CRD_W-1:0] nx;
    logic signed [CRD_W-1:0] ny;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic              ram_rdata;
    logic              outside;
    logic              blocked;
    logic [ACC_W-1:0]  hit_dist;
    logic [15:0]       wd_c;
    logic [H_W-1:0]    h_half;
    logic signed [H_W:0] top_s;
    logic [H_W-1:0]    bot_u;
    logic [CRD_W-1:0]  hx;
    logic [CRD_W-1:0]  hy;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign res_load    = (r_state == S_DONE) && (!r_res_valid || i_pop);

    assign n_prod  = i_cmd.screen_column * N_RECIP;

    assign mag_x   = DEN_W'(r_rx[RAY_W-1] ? -r_rx : r_rx);
    assign mag_y   = DEN_W'(r_ry[RAY_W-1] ? -r_ry : r_ry);
    assign div_sat = (|div_quo[NUM_W-1:32]) ? grc_pkg::DELTA_MAX : div_quo[31:0];

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        priority if (r_state == S_DXST && r_rx != '0) begin
            div_start = 1'b1;
            div_num   = NUM_W'({r_len, 16'b0});
            div_den   = mag_x;
        end else if (r_state == S_DYST && r_ry != '0) begin
            div_start = 1'b1;
            div_num   = NUM_W'({r_len, 16'b0});
            div_den   = mag_y;
        end else if (r_state == S_HST && r_wd != '0) begin
            div_start = 1'b1;
            div_num   = NUM_W'({SH_U, 8'b0});
            div_den   = DEN_W'(r_wd);
        end else begin
        end
    end

    assign sq_start = (r_state == S_SQST);
    assign sq_val   = SQ_W'(unsigned'(r_sqx)) + SQ_W'(unsigned'(r_sqy));

    assign fmx   = r_rx[RAY_W-1] ? {1'b0, i_cfg.player_x[9:0]}
                                 : 11'd1024 - {1'b0, i_cfg.player_x[9:0]};
    assign fmy   = r_ry[RAY_W-1] ? {1'b0, i_cfg.player_y[9:0]}
                                 : 11'd1024 - {1'b0, i_cfg.player_y[9:0]};
    assign mul_x = fmx * r_dx;
    assign mul_y = fmy * r_dy;

    assign step_x = r_sidex < r_sidey;
    assign nx     = r_negx ? r_mx - CRD_W'(1) : r_mx + CRD_W'(1);
    assign ny     = r_negy ? r_my - CRD_W'(1) : r_my + CRD_W'(1);

    assign outside  = r_mx[CRD_W-1] || r_my[CRD_W-1] || (r_mx >= MX_LIM) || (r_my >= MY_LIM);
    assign blocked  = outside || ram_rdata;
    assign hit_dist = r_side ? r_sidey - ACC_W'(r_dy) : r_sidex - ACC_W'(r_dx);
    assign wd_c     = (|hit_dist[ACC_W-1:24]) ? 16'hFFFF : hit_dist[23:8];

    assign h_half = div_quo[H_W-1:0] >> 1;
    assign top_s  = HALF_S - $signed({1'b0, h_half});
    assign bot_u  = HALF_U + h_half;

    assign hx = r_mx[CRD_W-1] ? '0 : (r_mx >= MX_LIM ? CRD_W'(MAP_WIDTH - 1) : r_mx);
    assign hy = r_my[CRD_W-1] ? '0 : (r_my >= MY_LIM ? CRD_W'(MAP_HEIGHT - 1) : r_my);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = 1'b0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (take && i_cmd.req_type == grc_pkg::REQ_WRITE) begin
            ram_we    = 1'b1;
            ram_waddr = {YW'(i_cmd.cell_y), XW'(i_cmd.cell_x)};
            ram_wdata = i_cmd.is_wall;
        end
    end

    assign ram_raddr = step_x ? {r_my[YW-1:0], nx[XW-1:0]} : {ny[YW-1:0], r_mx[XW-1:0]};

    grc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    grc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    grc_sqrt #(
        .SQ_W (SQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (take && i_cmd.req_type == grc_pkg::REQ_CAST) n_state = S_RAY;
            S_RAY:   n_state = S_RAY2;
            S_RAY2:  n_state = S_SQ;
            S_SQ:    n_state = S_SQST;
            S_SQST:  n_state = S_SQRT;
            S_SQRT:  if (sq_done) n_state = S_DXST;
            S_DXST:  n_state = (r_rx == '0) ? S_DYST : S_DX;
            S_DX:    if (div_done) n_state = S_DYST;
            S_DYST:  n_state = (r_ry == '0) ? S_INIT : S_DY;
            S_DY:    if (div_done) n_state = S_INIT;
            S_INIT:  n_state = S_WALK;
            S_WALK:  n_state = S_WCHK;
            S_WCHK:  n_state = blocked ? S_HST : S_WALK;
            S_HST:   n_state = (r_wd == '0) ? S_DONE : S_HDIV;
            S_HDIV:  if (div_done) n_state = S_DONE;
            S_DONE:  if (res_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (take && i_cmd.req_type == grc_pkg::REQ_CAST) begin
                    r_n <= $signed(N_W'(n_prod >> (N_FRAC - 15))) - N_BIAS;
                end
            end
            S_RAY: begin
                r_px <= i_cfg.camera_plane_x * r_n;
                r_py <= i_cfg.camera_plane_y * r_n;
            end
            S_RAY2: begin
                r_rx <= RAY_W'(i_cfg.view_dir_x) + RAY_W'(r_px >>> 14);
                r_ry <= RAY_W'(i_cfg.view_dir_y) + RAY_W'(r_py >>> 14);
            end
            S_SQ: begin
                r_sqx <= r_rx * r_rx;
                r_sqy <= r_ry * r_ry;
            end
            S_SQRT: begin
                if (sq_done) begin
                    r_len <= sq_root;
                end
            end
            S_DXST: begin
                if (r_rx == '0) begin
                    r_dx <= grc_pkg::DELTA_MAX;
                end
            end
            S_DX: begin
                if (div_done) begin
                    r_dx <= div_sat;
                end
            end
            S_DYST: begin
                if (r_ry == '0) begin
                    r_dy <= grc_pkg::DELTA_MAX;
                end
            end
            S_DY: begin
                if (div_done) begin
                    r_dy <= div_sat;
                end
            end
            S_INIT: begin
                r_sidex <= ACC_W'(mul_x >> 10);
                r_sidey <= ACC_W'(mul_y >> 10);
                r_mx    <= CRD_W'(i_cfg.player_x[15:10]);
                r_my    <= CRD_W'(i_cfg.player_y[15:10]);
                r_negx  <= r_rx[RAY_W-1];
                r_negy  <= r_ry[RAY_W-1];
            end
            S_WALK: begin
                if (step_x) begin
                    r_sidex <= r_sidex + ACC_W'(r_dx);
                    r_mx    <= nx;
                    r_side  <= 1'b0;
                end else begin
                    r_sidey <= r_sidey + ACC_W'(r_dy);
                    r_my    <= ny;
                    r_side  <= 1'b1;
                end
            end
            S_WCHK: begin
                if (blocked) begin
                    r_wd <= wd_c;
                end
            end
            S_HST: begin
                if (r_wd == '0) begin
                    r_top <= '0;
                    r_bot <= BOT_MAX;
                end
            end
            S_HDIV: begin
                if (div_done) begin
                    r_top <= top_s[H_W] ? '0 : top_s[7:0];
                    r_bot <= (bot_u >= SH_U) ? BOT_MAX : bot_u[7:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res.slice_top     <= r_top;
            r_res.slice_bottom  <= r_bot;
            r_res.shade         <= r_side ? grc_pkg::SHADE_HALF : grc_pkg::SHADE_FULL;
            r_res.hit_side      <= r_side;
            r_res.hit_cell_x    <= hx[5:0];
            r_res.hit_cell_y    <= hy[5:0];
            r_res.wall_distance <= r_wd;
        end
    end

    assign o_res              = r_res;
    assign o_status.clearing  = (r_state == S_CLEAR);
    assign o_status.res_valid = r_res_valid;

endmodule
